### rtl/lfs_pkg.sv
// shared types and constants for the line-follower steering core
// no dependencies; compiled first

package lfs_pkg;

    localparam int COUNTER_WIDTH = 16;
    localparam int DUTY_WIDTH    = 8;
    localparam int LIMIT_WIDTH   = 16;
    localparam int CFG_WIDTH     = 16;
    localparam int CFG_IDX_WIDTH = 2;
    localparam int CMP_WIDTH     = (COUNTER_WIDTH > LIMIT_WIDTH) ? COUNTER_WIDTH : LIMIT_WIDTH;

    typedef logic [COUNTER_WIDTH-1:0] lost_cnt_t;
    typedef logic [CMP_WIDTH-1:0]     lost_cmp_t;
    typedef logic [DUTY_WIDTH-1:0]    duty_t;
    typedef logic [LIMIT_WIDTH-1:0]   limit_t;

    localparam lost_cnt_t LOST_CNT_TOP = '1;

    localparam duty_t  FULL_DUTY_RST   = DUTY_WIDTH'(100);
    localparam duty_t  SHARP_DUTY_RST  = DUTY_WIDTH'(10);
    localparam duty_t  GENTLE_DUTY_RST = DUTY_WIDTH'(50);
    localparam limit_t LOST_LIMIT_RST  = LIMIT_WIDTH'(60000);

    // command characters
    localparam logic [7:0] CMD_STRAIGHT = 8'h30;
    localparam logic [7:0] CMD_STOP     = 8'h31;
    localparam logic [7:0] CMD_SHARP_B  = 8'h32;
    localparam logic [7:0] CMD_SHARP_A  = 8'h33;

    localparam logic REQ_SAMPLE  = 1'b0;
    localparam logic REQ_COMMAND = 1'b1;

    typedef enum logic [2:0] {
        MODE_NONE     = 3'd0,
        MODE_STRAIGHT = 3'd1,
        MODE_STOP     = 3'd2,
        MODE_SHARP_A  = 3'd3,
        MODE_SHARP_B  = 3'd4,
        MODE_GENTLE_A = 3'd5,
        MODE_GENTLE_B = 3'd6
    } mode_t;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_FULL_DUTY   = 2'd0,
        REG_SHARP_DUTY  = 2'd1,
        REG_GENTLE_DUTY = 2'd2,
        REG_LOST_LIMIT  = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        CLS_NONE,
        CLS_STRAIGHT,
        CLS_SHARP_A,
        CLS_SHARP_B,
        CLS_GENTLE_B,
        CLS_GENTLE_A,
        CLS_DARK
    } sample_class_t;

    typedef struct packed {
        logic                     we;
        logic [CFG_IDX_WIDTH-1:0] index;
        logic [CFG_WIDTH-1:0]     data;
    } cfg_wr_t;

    typedef struct packed {
        logic       req_type;
        logic [4:0] sensors;
        logic [7:0] cmd_byte;
    } item_t;

endpackage

### rtl/lfs_if.sv
// valid/ready channel interfaces for the steering core
// input items and result items; no package dependency

interface lfs_item_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [4:0] sensors;
    logic [7:0] cmd_byte;

    modport source (output valid, output req_type, output sensors, output cmd_byte,
                    input ready);
    modport sink   (input valid, input req_type, input sensors, input cmd_byte,
                    output ready);
endinterface

interface lfs_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] right_duty;
    logic [7:0] left_duty;
    logic [2:0] drive_mode;

    modport source (output valid, output right_duty, output left_duty, output drive_mode,
                    input ready);
    modport sink   (input valid, input right_duty, input left_duty, input drive_mode,
                    output ready);
endinterface

### rtl/line_follower_steering_core.sv
// top level of the line-follower steering core: input stage, beat control, result port
// depends on lfs_pkg, lfs_if, lfs_classify and lfs_steer

// Line-follower steering core. Each input beat is either a five-bit reflectance
// sample (req_type 0) or a command byte (req_type 1); every beat yields exactly
// one result beat carrying the right and left wheel duties and the drive mode.
// Command bytes '0'..'3' set the remembered mode (straight, stop, sharp B,
// sharp A) used when the sensors see all dark; other bytes leave everything
// as it was. Throughput is one beat per clock while the result consumer keeps
// ready high; an accepted beat is loaded into the input register, then carried
// through the steering update into the state/result register, from which the
// result is offered. The steering update is a single stage, so the mode, counter
// and duties of one beat are ready for the next beat in the following cycle.
// Input ready stays high while the result register is full but the input
// register is free, so a stalled consumer costs one beat of buffering before
// backpressure reaches the input. Configuration writes (cfg_we, cfg_index,
// cfg_data) go straight into the config registers and must only be issued
// while no beat is in flight.

module line_follower_steering_core import lfs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    lfs_item_if.sink                 item,
    lfs_result_if.source             result,
    input  logic                     cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]     cfg_data
);

    // input register
    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg;
    // result register occupancy; payload lives in the steering state
    logic    out_valid_reg, out_valid_next;

    logic    in_fire;
    logic    advance;
    cfg_wr_t cfg;
    duty_t   right_duty, left_duty;
    mode_t   drive_mode;

    // move the held beat into the result register when that slot is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;
    assign in_fire = item.valid && item.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_fire)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_item_reg.req_type <= item.req_type;
            in_item_reg.sensors  <= item.sensors;
            in_item_reg.cmd_byte <= item.cmd_byte;
        end
    end

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    lfs_steer u_steer
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .advance    (advance),
        .item       (in_item_reg),
        .right_duty (right_duty),
        .left_duty  (left_duty),
        .drive_mode (drive_mode)
    );

    // steering state only changes on advance, so it holds steady as the result payload
    assign result.valid      = out_valid_reg;
    assign result.right_duty = right_duty;
    assign result.left_duty  = left_duty;
    assign result.drive_mode = drive_mode;

    // a beat never advances into a full result register that is not draining
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !result.ready |-> !advance)
        else $error("result overwritten while stalled");

    // a held input beat advances whenever the result slot is free
    a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !out_valid_reg |-> advance)
        else $error("input beat held with free result slot");

    // a beat that advances shows up in the result register in the next cycle
    a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced beat missing from result register");

endmodule

### rtl/lfs_classify.sv
// priority decode of a five-bit reflectance sample into a pattern class
// depends on lfs_pkg

module lfs_classify import lfs_pkg::*;
(
    input  logic [4:0]    sensors,
    output sample_class_t sample_class
);

    logic s1, s2, s3, s4, s5;

    assign s1 = sensors[0];
    assign s2 = sensors[1];
    assign s3 = sensors[2];
    assign s4 = sensors[3];
    assign s5 = sensors[4];

    // first match wins
    always_comb
    begin
        if (s1 && s2 && !s3 && s4 && s5)
            sample_class = CLS_STRAIGHT;
        else if ((s1 || s2) && !s4 && !s5)
            sample_class = CLS_SHARP_A;
        else if (!s1 && !s2 && (s4 || s5))
            sample_class = CLS_SHARP_B;
        else if ((s1 || s2) && !s4)
            sample_class = CLS_GENTLE_B;
        else if (!s2 && (s4 || s5))
            sample_class = CLS_GENTLE_A;
        else if (sensors == 5'd0)
            sample_class = CLS_DARK;
        else
            sample_class = CLS_NONE;
    end

endmodule

### rtl/lfs_steer.sv
// steering state: config registers, mode, remembered mode, lost-line counter, duties
// depends on lfs_pkg and lfs_classify

module lfs_steer import lfs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_wr_t cfg,
    input  logic    advance,
    input  item_t   item,
    output duty_t   right_duty,
    output duty_t   left_duty,
    output mode_t   drive_mode
);

    duty_t     full_duty_reg, sharp_duty_reg, gentle_duty_reg;
    limit_t    lost_limit_reg;
    mode_t     mode_reg, mode_next;
    mode_t     rem_reg, rem_next;
    mode_t     mode_sel;
    lost_cnt_t cnt_reg, cnt_next;
    duty_t     right_reg, right_next;
    duty_t     left_reg, left_next;
    sample_class_t sample_class;

    lfs_classify u_classify
    (
        .sensors      (item.sensors),
        .sample_class (sample_class)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_duty_reg   <= FULL_DUTY_RST;
            sharp_duty_reg  <= SHARP_DUTY_RST;
            gentle_duty_reg <= GENTLE_DUTY_RST;
            lost_limit_reg  <= LOST_LIMIT_RST;
        end
        else if (cfg.we)
        begin
            case (cfg_reg_t'(cfg.index))
                REG_FULL_DUTY:   full_duty_reg   <= cfg.data[DUTY_WIDTH-1:0];
                REG_SHARP_DUTY:  sharp_duty_reg  <= cfg.data[DUTY_WIDTH-1:0];
                REG_GENTLE_DUTY: gentle_duty_reg <= cfg.data[DUTY_WIDTH-1:0];
                REG_LOST_LIMIT:  lost_limit_reg  <= cfg.data[LIMIT_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        right_next = right_reg;
        left_next  = left_reg;
        mode_sel   = mode_reg;
        if (advance)
        begin
            if (item.req_type == REQ_SAMPLE)
            begin
                case (sample_class)
                    CLS_STRAIGHT: mode_sel = MODE_STRAIGHT;
                    CLS_SHARP_A:  mode_sel = MODE_SHARP_A;
                    CLS_SHARP_B:  mode_sel = MODE_SHARP_B;
                    CLS_GENTLE_B: mode_sel = MODE_GENTLE_B;
                    CLS_GENTLE_A: mode_sel = MODE_GENTLE_A;
                    CLS_DARK:
                    begin
                        // line lost: count while going straight, force a turn past the limit
                        if (rem_reg == MODE_STRAIGHT && cnt_reg != LOST_CNT_TOP)
                            cnt_next = cnt_reg + lost_cnt_t'(1);
                        if (rem_reg == MODE_STRAIGHT &&
                            lost_cmp_t'(cnt_next) > lost_cmp_t'(lost_limit_reg))
                            mode_sel = MODE_SHARP_A;
                        else
                            mode_sel = rem_reg;
                    end
                    default: mode_sel = mode_reg;
                endcase
                mode_next = mode_sel;
                case (mode_sel)
                    MODE_STRAIGHT:
                    begin
                        right_next = full_duty_reg;
                        left_next  = full_duty_reg;
                    end
                    MODE_STOP:
                    begin
                        right_next = '0;
                        left_next  = '0;
                    end
                    MODE_SHARP_A:
                    begin
                        right_next = full_duty_reg;
                        left_next  = sharp_duty_reg;
                    end
                    MODE_SHARP_B:
                    begin
                        right_next = sharp_duty_reg;
                        left_next  = full_duty_reg;
                    end
                    MODE_GENTLE_A:
                    begin
                        right_next = gentle_duty_reg;
                        left_next  = full_duty_reg;
                    end
                    MODE_GENTLE_B:
                    begin
                        right_next = full_duty_reg;
                        left_next  = gentle_duty_reg;
                    end
                    default: ;
                endcase
            end
            else
            begin
                case (item.cmd_byte)
                    CMD_STRAIGHT: rem_next = MODE_STRAIGHT;
                    CMD_STOP:     rem_next = MODE_STOP;
                    CMD_SHARP_B:  rem_next = MODE_SHARP_B;
                    CMD_SHARP_A:  rem_next = MODE_SHARP_A;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_NONE;
            rem_reg   <= MODE_NONE;
            cnt_reg   <= '0;
            right_reg <= '0;
            left_reg  <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            rem_reg   <= rem_next;
            cnt_reg   <= cnt_next;
            right_reg <= right_next;
            left_reg  <= left_next;
        end
    end

    assign right_duty = right_reg;
    assign left_duty  = left_reg;
    assign drive_mode = mode_reg;

    // a command beat never touches mode or duties
    a_cmd_keeps_drive: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item.req_type == REQ_COMMAND |=>
            $stable(mode_reg) && $stable(right_reg) && $stable(left_reg))
        else $error("command beat changed drive state");

    // lost-line counter only grows
    a_cnt_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> cnt_reg >= $past(cnt_reg))
        else $error("lost-line counter decreased");

    // counter only moves while the remembered mode is straight
    a_cnt_only_straight: assert property (@(posedge clk) disable iff (!rst_n)
        rem_reg != MODE_STRAIGHT |=> $stable(cnt_reg))
        else $error("lost-line counter moved outside straight");

    // stop always drives both wheels to zero
    a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_STOP |-> right_reg == '0 && left_reg == '0)
        else $error("stop mode with nonzero duty");

endmodule
